@@ hdl/bcfa_pkg.sv @@
// Shared types, codes and constants of the block chain file allocator.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none
package bcfa_pkg;

   localparam int MAX_SLOTS_DEF  = 16;
   localparam int MAX_BLOCKS_DEF = 128;

   // Block size is fixed: byte offset is the low bits of a position.
   localparam int BLOCK_BYTES = 64;
   localparam int OFS_W       = 6;
   // Blocks needed by a resize: ceil(new_size / BLOCK_BYTES), 9 bits.
   localparam int CNT_W       = 9;

   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_RESIZE = 2'd1;
   localparam logic [1:0] OP_WRITE  = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SLOT  = 2'd1;
   localparam logic [1:0] ST_NO_BLOCK = 2'd2;
   localparam logic [1:0] ST_BAD_POS  = 2'd3;

   localparam logic CSR_SLOTS  = 1'b0;
   localparam logic CSR_BLOCKS = 1'b1;

   localparam logic [4:0] SLOTS_RESET  = 5'd10;
   localparam logic [7:0] BLOCKS_RESET = 8'd100;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [3:0]  file_id;
      logic [13:0] new_size;
      logic [12:0] position;
      logic [7:0]  data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] file_id_out;
      logic [6:0] block_out;
   } rsp_payload_type;

   typedef struct packed {
      logic       load;
      logic       idx_clr;
      logic       idx_inc;
      logic       slot_take;
      logic       alloc_commit;
      logic       rd_b;
      logic       rd_c;
      logic       step_b;
      logic       set_c;
      logic       step_c;
      logic       free_c;
      logic       cnt_free;
      logic       append;
      logic       fin_link;
      logic       byte_store;
      logic       set_status;
      logic [1:0] status;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] req_op;
      logic [1:0] op;
      logic       slot_ok;
      logic       slot_end;
      logic       blk_end;
      logic       slot_free;
      logic       blk_free;
      logic       link_next;
      logic       cnt_zero;
      logic       cnt_one;
      logic       short_free;
      logic       guard_last;
      logic       out_busy;
   } dp_stat_type;

endpackage
`default_nettype wire

@@ hdl/bcfa_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module bcfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

@@ hdl/bcfa_ctrl.sv @@
// Sequencer of the allocator: scans, chain walks, append and tail free.
// Depends on bcfa_pkg; drives bcfa_dp through dp_cmd_type.
`default_nettype none
module bcfa_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire bcfa_pkg::dp_stat_type stat,
   output bcfa_pkg::dp_cmd_type      cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SLOT_SCAN = 4'd1;
   localparam logic [3:0] S_BLK_SCAN  = 4'd2;
   localparam logic [3:0] S_WALK_RD   = 4'd3;
   localparam logic [3:0] S_WALK_CHK  = 4'd4;
   localparam logic [3:0] S_CNT_SCAN  = 4'd5;
   localparam logic [3:0] S_APPEND    = 4'd6;
   localparam logic [3:0] S_FREE_RD   = 4'd7;
   localparam logic [3:0] S_FREE_CHK  = 4'd8;
   localparam logic [3:0] S_FINISH    = 4'd9;
   localparam logic [3:0] S_DONE      = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (stat.req_op)
                  bcfa_pkg::OP_ALLOC: state_in = S_SLOT_SCAN;
                  bcfa_pkg::OP_RESIZE,
                  bcfa_pkg::OP_WRITE: begin
                     if (stat.slot_ok) begin
                        state_in = S_WALK_RD;
                     end else begin
                        cmd.set_status = 1'b1;
                        cmd.status     = bcfa_pkg::ST_BAD_POS;
                        state_in       = S_DONE;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SLOT_SCAN: begin
            if (stat.slot_end) begin
               cmd.set_status = 1'b1;
               cmd.status     = bcfa_pkg::ST_NO_SLOT;
               state_in       = S_DONE;
            end else if (stat.slot_free) begin
               cmd.slot_take = 1'b1;
               cmd.idx_clr   = 1'b1;
               state_in      = S_BLK_SCAN;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_BLK_SCAN: begin
            if (stat.blk_end) begin
               cmd.set_status = 1'b1;
               cmd.status     = bcfa_pkg::ST_NO_BLOCK;
               state_in       = S_DONE;
            end else if (stat.blk_free) begin
               cmd.alloc_commit = 1'b1;
               state_in         = S_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_WALK_RD: begin
            cmd.rd_b = 1'b1;
            state_in = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            if (!stat.cnt_zero && stat.link_next) begin
               cmd.step_b = 1'b1;
               state_in   = S_WALK_RD;
            end else if (stat.op == bcfa_pkg::OP_WRITE) begin
               if (!stat.cnt_zero) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = bcfa_pkg::ST_BAD_POS;
               end else begin
                  cmd.byte_store = 1'b1;
               end
               state_in = S_DONE;
            end else if (!stat.cnt_zero) begin
               state_in = S_CNT_SCAN;
            end else if (stat.link_next) begin
               cmd.set_c = 1'b1;
               state_in  = S_FREE_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_CNT_SCAN: begin
            if (stat.blk_end) begin
               if (stat.short_free) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = bcfa_pkg::ST_NO_BLOCK;
                  state_in       = S_DONE;
               end else begin
                  cmd.idx_clr = 1'b1;
                  state_in    = S_APPEND;
               end
            end else begin
               cmd.cnt_free = 1'b1;
               cmd.idx_inc  = 1'b1;
            end
         end
         S_APPEND: begin
            cmd.idx_inc = 1'b1;
            if (stat.blk_free) begin
               cmd.append = 1'b1;
               if (stat.cnt_one) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FREE_RD: begin
            cmd.rd_c = 1'b1;
            state_in = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            cmd.free_c = 1'b1;
            if (stat.link_next && !stat.guard_last) begin
               cmd.step_c = 1'b1;
               state_in   = S_FREE_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.fin_link = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/bcfa_dp.sv @@
// Datapath: registers, slot table, block-use bits, link and byte RAMs, result register.
// Depends on bcfa_pkg and bcfa_ram; commanded by bcfa_ctrl.
`default_nettype none
module bcfa_dp #(
   parameter int MAX_SLOTS  = bcfa_pkg::MAX_SLOTS_DEF,
   parameter int MAX_BLOCKS = bcfa_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire bcfa_pkg::req_payload_type req_payload,
   input  wire logic                     csr_write_enable,
   input  wire logic                     csr_index,
   input  wire logic [7:0]               csr_write_data,
   input  wire bcfa_pkg::dp_cmd_type     cmd,
   output bcfa_pkg::dp_stat_type         stat,
   output logic                          rsp_valid,
   output bcfa_pkg::rsp_payload_type     rsp_payload,
   input  wire logic                     rsp_stall
);

   localparam int SW      = $clog2(MAX_SLOTS);
   localparam int BW      = $clog2(MAX_BLOCKS);
   localparam int IDX_MAX = (MAX_SLOTS > MAX_BLOCKS) ? MAX_SLOTS : MAX_BLOCKS;
   localparam int IW      = $clog2(IDX_MAX + 1);
   localparam int CW      = $clog2(MAX_BLOCKS + 1);
   localparam int NW      = bcfa_pkg::CNT_W;
   localparam int OW      = bcfa_pkg::OFS_W;
   localparam int DEPTH   = MAX_BLOCKS * bcfa_pkg::BLOCK_BYTES;

   logic [4:0]    slots_ff, slots_in;
   logic [7:0]    blocks_ff, blocks_in;
   logic          slot_valid_ff [MAX_SLOTS];
   logic          slot_valid_in [MAX_SLOTS];
   logic [BW-1:0] slot_first_ff [MAX_SLOTS];
   logic [BW-1:0] slot_first_in [MAX_SLOTS];
   logic          used_ff [MAX_BLOCKS];
   logic          used_in [MAX_BLOCKS];
   logic [1:0]    op_ff, op_in;
   logic [3:0]    id_ff, id_in;
   logic [OW-1:0] ofs_ff, ofs_in;
   logic [7:0]    byte_ff, byte_in;
   logic [BW-1:0] b_ff, b_in;
   logic [BW-1:0] c_ff, c_in;
   logic [SW-1:0] s_ff, s_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] guard_ff, guard_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [1:0]    status_ff, status_in;
   logic [BW-1:0] blk_ff, blk_in;
   logic [BW-1:0] rd_addr_ff, rd_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   bcfa_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [IW-1:0] fid_ext;
   logic          fid_ok;
   logic [14:0]   size_sum;
   logic [NW-1:0] need_raw;
   logic [NW-1:0] cnt_load;
   logic          link_we;
   logic [BW-1:0] link_wa;
   logic [BW:0]   link_wd;
   logic [BW-1:0] link_ra;
   logic [BW:0]   link_rd;

   assign fid_ext  = IW'(req_payload.file_id);
   assign fid_ok   = 16'(req_payload.file_id) < 16'(MAX_SLOTS);
   assign size_sum = {1'b0, req_payload.new_size} + 15'(bcfa_pkg::BLOCK_BYTES - 1);
   assign need_raw = NW'(size_sum >> OW);

   always_comb begin
      if (req_payload.opcode == bcfa_pkg::OP_RESIZE) begin
         cnt_load = (need_raw == '0) ? '0 : need_raw - NW'(1);
      end else begin
         cnt_load = NW'(req_payload.position >> OW);
      end
   end

   // Link RAM: one write and one read per cycle.
   assign link_ra = cmd.rd_c ? c_ff : b_ff;
   always_comb begin
      link_we = cmd.append | cmd.alloc_commit | cmd.fin_link;
      link_wa = b_ff;
      link_wd = '0;
      if (cmd.append) begin
         link_wd = {1'b1, idx_ff[BW-1:0]};
      end else if (cmd.alloc_commit) begin
         link_wa = idx_ff[BW-1:0];
      end
   end

   bcfa_ram #(.WIDTH(BW + 1), .DEPTH(MAX_BLOCKS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   bcfa_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_byte_ram (
      .clock   (clock),
      .wr_en   (cmd.byte_store),
      .wr_addr ({b_ff, ofs_ff}),
      .wr_data (byte_ff),
      .rd_addr ({b_ff, ofs_ff}),
      .rd_data ()
   );

   always_comb begin
      stat.req_op     = req_payload.opcode;
      stat.op         = op_ff;
      stat.slot_ok    = fid_ok && slot_valid_ff[fid_ext[SW-1:0]];
      stat.slot_end   = (16'(idx_ff) >= 16'(slots_ff)) || (16'(idx_ff) >= 16'(MAX_SLOTS));
      stat.blk_end    = (16'(idx_ff) >= 16'(blocks_ff)) || (16'(idx_ff) >= 16'(MAX_BLOCKS));
      stat.slot_free  = !slot_valid_ff[idx_ff[SW-1:0]];
      stat.blk_free   = !used_ff[idx_ff[BW-1:0]];
      stat.link_next  = used_ff[rd_addr_ff] && link_rd[BW];
      stat.cnt_zero   = (cnt_ff == '0);
      stat.cnt_one    = (cnt_ff == NW'(1));
      stat.short_free = 16'(count_ff) < 16'(cnt_ff);
      stat.guard_last = (16'(guard_ff) == 16'(MAX_BLOCKS - 1));
      stat.out_busy   = rsp_valid_ff && rsp_stall;
   end

   always_comb begin
      slots_in      = slots_ff;
      blocks_in     = blocks_ff;
      slot_valid_in = slot_valid_ff;
      slot_first_in = slot_first_ff;
      used_in       = used_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      ofs_in        = ofs_ff;
      byte_in       = byte_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      s_in          = s_ff;
      cnt_in        = cnt_ff;
      count_in      = count_ff;
      guard_in      = guard_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      blk_in        = blk_ff;
      rd_addr_in    = rd_addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (csr_write_enable) begin
         if (csr_index == bcfa_pkg::CSR_SLOTS) begin
            slots_in = csr_write_data[4:0];
         end else begin
            blocks_in = csr_write_data;
         end
      end

      if (cmd.load) begin
         op_in     = req_payload.opcode;
         id_in     = req_payload.file_id;
         ofs_in    = req_payload.position[OW-1:0];
         byte_in   = req_payload.data_byte;
         b_in      = slot_first_ff[fid_ext[SW-1:0]];
         cnt_in    = cnt_load;
         count_in  = '0;
         guard_in  = '0;
         idx_in    = '0;
         status_in = bcfa_pkg::ST_OK;
         blk_in    = '0;
      end

      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IW'(1);
      end

      if (cmd.slot_take) begin
         s_in = idx_ff[SW-1:0];
      end

      if (cmd.alloc_commit) begin
         slot_valid_in[s_ff]       = 1'b1;
         slot_first_in[s_ff]       = idx_ff[BW-1:0];
         used_in[idx_ff[BW-1:0]]   = 1'b1;
         id_in                     = 4'(s_ff);
         blk_in                    = idx_ff[BW-1:0];
      end

      if (cmd.rd_b) begin
         rd_addr_in = b_ff;
      end else if (cmd.rd_c) begin
         rd_addr_in = c_ff;
      end

      if (cmd.step_b) begin
         b_in   = link_rd[BW-1:0];
         cnt_in = cnt_ff - NW'(1);
      end

      if (cmd.set_c) begin
         c_in = link_rd[BW-1:0];
      end

      if (cmd.step_c) begin
         c_in     = link_rd[BW-1:0];
         guard_in = guard_ff + CW'(1);
      end

      if (cmd.free_c) begin
         used_in[rd_addr_ff] = 1'b0;
      end

      if (cmd.cnt_free && !used_ff[idx_ff[BW-1:0]]) begin
         count_in = count_ff + CW'(1);
      end

      if (cmd.append) begin
         used_in[idx_ff[BW-1:0]] = 1'b1;
         b_in                    = idx_ff[BW-1:0];
         cnt_in                  = cnt_ff - NW'(1);
      end

      if (cmd.fin_link || cmd.byte_store) begin
         blk_in = b_ff;
      end

      if (cmd.set_status) begin
         status_in = cmd.status;
      end

      // Drop the result once taken; load the next when the controller finishes.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = status_ff;
         rsp_in.file_id_out = id_ff;
         rsp_in.block_out   = 7'(blk_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff     <= bcfa_pkg::SLOTS_RESET;
         blocks_ff    <= bcfa_pkg::BLOCKS_RESET;
         slot_valid_ff <= '{default: 1'b0};
         used_ff      <= '{default: 1'b0};
         rsp_valid_ff <= 1'b0;
      end else begin
         slots_ff     <= slots_in;
         blocks_ff    <= blocks_in;
         slot_valid_ff <= slot_valid_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_first_ff <= slot_first_in;
      op_ff         <= op_in;
      id_ff         <= id_in;
      ofs_ff        <= ofs_in;
      byte_ff       <= byte_in;
      b_ff          <= b_in;
      c_ff          <= c_in;
      s_ff          <= s_in;
      cnt_ff        <= cnt_in;
      count_ff      <= count_in;
      guard_ff      <= guard_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      blk_ff        <= blk_in;
      rd_addr_ff    <= rd_addr_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

@@ hdl/block_chain_file_allocator.sv @@
// Block chain file allocator: top level, joins sequencer (bcfa_ctrl) and datapath (bcfa_dp).
// One transaction in flight; the time until the result register loads after acceptance is
// set by the slot/block scans (one entry a cycle), the chain walk and tail free (a RAM read
// and a check state per link), and the free count and append scans; result stalls add.
// Throughput: the next transaction is taken once the result sits in the output register.
// Reset (synchronous, active high): all slots empty, all blocks free, registers 10 and 100.
`default_nettype none
module block_chain_file_allocator #(
   parameter int MAX_SLOTS  = bcfa_pkg::MAX_SLOTS_DEF,
   parameter int MAX_BLOCKS = bcfa_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire bcfa_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output bcfa_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                      csr_write_enable,
   input  wire logic                      csr_index,
   input  wire logic [7:0]                csr_write_data
);

   bcfa_pkg::dp_cmd_type  cmd;
   bcfa_pkg::dp_stat_type stat;

   // Sequencer: accepts a transaction only when idle, steps the datapath.
   bcfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: tables, link and byte RAMs, result register.
   bcfa_dp #(.MAX_SLOTS(MAX_SLOTS), .MAX_BLOCKS(MAX_BLOCKS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload),
      .rsp_stall        (rsp_stall)
   );

   // A failed transaction reports no block.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status != bcfa_pkg::ST_OK)) |-> (rsp_payload.block_out == 7'd0))
      else $error("error status with nonzero block");

   // Every accepted transaction occupies the sequencer: req_stall is high in the cycle after acceptance.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sequencer took two transactions back to back");

   // The sequencer never asks for both link reads in one step.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_b && cmd.rd_c))
      else $error("conflicting link reads");

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench of block_chain_file_allocator: a predictor of the file table tracks
// slots and block links, random and directed transactions go through valid/stall handshakes.
// Depends on hdl/bcfa_pkg.sv and hdl/block_chain_file_allocator.sv.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

   localparam int NSLOT = 16;
   localparam int NBLK  = 128;
   // Link kinds of the predicted block table.
   localparam logic [1:0] LK_FREE = 2'd0;
   localparam logic [1:0] LK_END  = 2'd1;
   localparam logic [1:0] LK_NEXT = 2'd2;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   bcfa_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   bcfa_pkg::rsp_payload_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic csr_index = bcfa_pkg::CSR_SLOTS;
   logic [7:0] csr_write_data = '0;

   block_chain_file_allocator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted file table state.
   int unsigned slot_limit, block_limit;
   bit          slot_used [NSLOT];
   int unsigned slot_head [NSLOT];
   logic [1:0]  link_kind [NBLK];
   int unsigned link_to [NBLK];

   bcfa_pkg::req_payload_type pending_reqs[$];
   bcfa_pkg::rsp_payload_type expected_rsps[$];
   int  failures = 0;
   bit  stim_done = 1'b0;

   function automatic int find_free_block();
      int n;
      n = block_limit > NBLK ? NBLK : block_limit;
      for (int i = 0; i < n; i++) if (link_kind[i] == LK_FREE) return i;
      return -1;
   endfunction

   function automatic int count_free_blocks();
      int n, c;
      n = block_limit > NBLK ? NBLK : block_limit;
      c = 0;
      for (int i = 0; i < n; i++) if (link_kind[i] == LK_FREE) c++;
      return c;
   endfunction

   // Apply one transaction to the table and return the result it must produce.
   function automatic bcfa_pkg::rsp_payload_type apply_table_op(bcfa_pkg::req_payload_type r);
      bcfa_pkg::rsp_payload_type o;
      int ns, s, b, f, len, need, togo, c, nx;
      logic [1:0] k;
      o.status = bcfa_pkg::ST_OK;
      o.file_id_out = r.file_id;
      o.block_out = '0;
      case (r.opcode)
         bcfa_pkg::OP_ALLOC: begin
            ns = slot_limit > NSLOT ? NSLOT : slot_limit;
            s = -1;
            for (int i = 0; i < ns; i++) if (s < 0 && !slot_used[i]) s = i;
            b = find_free_block();
            if (s < 0) o.status = bcfa_pkg::ST_NO_SLOT;
            else if (b < 0) o.status = bcfa_pkg::ST_NO_BLOCK;
            else begin
               slot_used[s] = 1'b1;
               slot_head[s] = b;
               link_kind[b] = LK_END;
               o.file_id_out = 4'(s);
               o.block_out = 7'(b);
            end
         end
         bcfa_pkg::OP_RESIZE: begin
            if (!slot_used[r.file_id]) o.status = bcfa_pkg::ST_BAD_POS;
            else begin
               need = (r.new_size + bcfa_pkg::BLOCK_BYTES - 1) / bcfa_pkg::BLOCK_BYTES;
               if (need == 0) need = 1;
               b = slot_head[r.file_id];
               len = 1;
               while (len < need && link_kind[b] == LK_NEXT && len < NBLK) begin
                  b = link_to[b];
                  len++;
               end
               if (len < need) begin
                  if (count_free_blocks() < need - len) o.status = bcfa_pkg::ST_NO_BLOCK;
                  else begin
                     while (len < need) begin
                        f = find_free_block();
                        if (f < 0) break;
                        link_kind[b] = LK_NEXT;
                        link_to[b] = f;
                        link_kind[f] = LK_END;
                        b = f;
                        len++;
                     end
                     o.block_out = 7'(b);
                  end
               end else begin
                  if (link_kind[b] == LK_NEXT) begin
                     c = link_to[b];
                     for (int g = 0; g < NBLK; g++) begin
                        k = link_kind[c];
                        nx = link_to[c];
                        link_kind[c] = LK_FREE;
                        link_to[c] = 0;
                        if (k != LK_NEXT) break;
                        c = nx;
                     end
                  end
                  link_kind[b] = LK_END;
                  link_to[b] = 0;
                  o.block_out = 7'(b);
               end
            end
         end
         bcfa_pkg::OP_WRITE: begin
            if (!slot_used[r.file_id]) o.status = bcfa_pkg::ST_BAD_POS;
            else begin
               togo = r.position / bcfa_pkg::BLOCK_BYTES;
               b = slot_head[r.file_id];
               while (togo > 0 && link_kind[b] == LK_NEXT) begin
                  b = link_to[b];
                  togo--;
               end
               if (togo > 0) o.status = bcfa_pkg::ST_BAD_POS;
               else o.block_out = 7'(b);
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // Driver: present the next pending transaction after a random gap, hold it while stalled.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(apply_table_op(req_payload));
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_valid <= 1'b1;
               req_payload <= pending_reqs.pop_front();
               send_gap = ($urandom_range(0, 9) < 6) ? 0 :
                          ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300)
                                                       : $urandom_range(1, 4);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result with the oldest expectation; stall at random.
   int stall_run = 0;
   bcfa_pkg::rsp_payload_type exp_rsp;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result %p", rsp_payload);
               failures++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_payload.status !== exp_rsp.status) begin
                  $error("status expected %0d actual %0d", exp_rsp.status, rsp_payload.status);
                  failures++;
               end
               if (rsp_payload.file_id_out !== exp_rsp.file_id_out) begin
                  $error("file_id_out expected %0d actual %0d",
                         exp_rsp.file_id_out, rsp_payload.file_id_out);
                  failures++;
               end
               if (rsp_payload.block_out !== exp_rsp.block_out) begin
                  $error("block_out expected %0d actual %0d",
                         exp_rsp.block_out, rsp_payload.block_out);
                  failures++;
               end
            end
         end
         if (stall_run > 0) begin
            stall_run--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 9) < 3) begin
            stall_run = ($urandom_range(0, 14) == 0) ? $urandom_range(20, 200)
                                                     : $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic bcfa_pkg::req_payload_type make_req(logic [1:0] op, logic [3:0] id,
                                                          logic [13:0] sz, logic [12:0] pos,
                                                          logic [7:0] dat);
      bcfa_pkg::req_payload_type r;
      r.opcode = op;
      r.file_id = id;
      r.new_size = sz;
      r.position = pos;
      r.data_byte = dat;
      return r;
   endfunction

   // Random transaction biased toward file ids 0 to 5 and small sizes and positions.
   function automatic bcfa_pkg::req_payload_type random_req();
      bcfa_pkg::req_payload_type r;
      int pick;
      r.file_id = 4'($urandom);
      r.new_size = 14'($urandom);
      r.position = 13'($urandom);
      r.data_byte = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 15) r.opcode = bcfa_pkg::OP_ALLOC;
      else if (pick < 50) r.opcode = bcfa_pkg::OP_RESIZE;
      else if (pick < 97) r.opcode = bcfa_pkg::OP_WRITE;
      else r.opcode = bcfa_pkg::OP_NOP;
      if ($urandom_range(0, 9) < 8) r.file_id = 4'($urandom_range(0, 5));
      if ($urandom_range(0, 9) < 8) r.new_size = 14'($urandom_range(0, 1200));
      if ($urandom_range(0, 9) < 8) r.position = 13'($urandom_range(0, 1300));
      return r;
   endfunction

   // Wait until the block is idle; write_reg below writes one register.
   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [7:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      if (idx == bcfa_pkg::CSR_SLOTS) slot_limit = 32'(val[4:0]);
      else block_limit = 32'(val);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      slot_limit = 32'(bcfa_pkg::SLOTS_RESET);
      block_limit = 32'(bcfa_pkg::BLOCKS_RESET);
      for (int i = 0; i < NSLOT; i++) begin
         slot_used[i] = 1'b0;
         slot_head[i] = 0;
      end
      for (int i = 0; i < NBLK; i++) begin
         link_kind[i] = LK_FREE;
         link_to[i] = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-slot errors, allocations, growth, shrink, writes past the end.
      pending_reqs.push_back(make_req(bcfa_pkg::OP_RESIZE, 4'd15, 14'd100, '0, '0));
      pending_reqs.push_back(make_req(bcfa_pkg::OP_WRITE, 4'd0, '0, '0, 8'hFF));
      pending_reqs.push_back(make_req(bcfa_pkg::OP_ALLOC, 4'd9, '0, '0, '0));
      pending_reqs.push_back(make_req(bcfa_pkg::OP_ALLOC, 4'd0, '0, '0, '0));
      pending_reqs.push_back(make_req(bcfa_pkg::OP_RESIZE, 4'd0, 14'd8192, '0, '0));
      pending_reqs.push_back(make_req(bcfa_pkg::OP_RESIZE, 4'd0, 14'd640, '0, '0));
      pending_reqs.push_back(make_req(bcfa_pkg::OP_WRITE, 4'd0, '0, 13'd639, 8'hA5));
      pending_reqs.push_back(make_req(bcfa_pkg::OP_WRITE, 4'd0, '0, 13'd640, 8'h5A));
      pending_reqs.push_back(make_req(bcfa_pkg::OP_WRITE, 4'd0, '0, 13'd8191, 8'h00));
      pending_reqs.push_back(make_req(bcfa_pkg::OP_RESIZE, 4'd1, 14'd16383, '0, '0));
      pending_reqs.push_back(make_req(bcfa_pkg::OP_RESIZE, 4'd0, 14'd0, '0, '0));
      pending_reqs.push_back(make_req(bcfa_pkg::OP_WRITE, 4'd0, '0, 13'd64, 8'h11));
      pending_reqs.push_back(make_req(bcfa_pkg::OP_NOP, 4'd7, 14'h3FFF, 13'h1FFF, 8'hFF));
      pending_reqs.push_back(make_req(bcfa_pkg::OP_RESIZE, 4'd1, 14'd6336, '0, '0));
      pending_reqs.push_back(make_req(bcfa_pkg::OP_RESIZE, 4'd1, 14'd64, '0, '0));
      wait_idle();

      // Zero limits: allocation and growth must fail.
      write_reg(bcfa_pkg::CSR_SLOTS, 8'd0);
      write_reg(bcfa_pkg::CSR_BLOCKS, 8'd0);
      pending_reqs.push_back(make_req(bcfa_pkg::OP_ALLOC, 4'd3, '0, '0, '0));
      pending_reqs.push_back(make_req(bcfa_pkg::OP_RESIZE, 4'd0, 14'd200, '0, '0));
      wait_idle();
      // Allocate until the blocks run out while slots remain, then run random phases.
      write_reg(bcfa_pkg::CSR_SLOTS, 8'd31);
      write_reg(bcfa_pkg::CSR_BLOCKS, 8'd12);
      for (int i = 0; i < 14; i++)
         pending_reqs.push_back(make_req(bcfa_pkg::OP_ALLOC, '0, '0, '0, '0));
      wait_idle();
      write_reg(bcfa_pkg::CSR_SLOTS, 8'd16);
      write_reg(bcfa_pkg::CSR_BLOCKS, 8'd255);
      for (int p = 0; p < 5; p++) begin
         for (int i = 0; i < 200; i++) pending_reqs.push_back(random_req());
         wait_idle();
         case (p)
            0: begin
               write_reg(bcfa_pkg::CSR_SLOTS, 8'd1);
               write_reg(bcfa_pkg::CSR_BLOCKS, 8'd128);
            end
            1: begin
               write_reg(bcfa_pkg::CSR_SLOTS, 8'd6);
               write_reg(bcfa_pkg::CSR_BLOCKS, 8'd20);
            end
            2: begin
               write_reg(bcfa_pkg::CSR_SLOTS, 8'd16);
               write_reg(bcfa_pkg::CSR_BLOCKS, 8'd1);
            end
            default: begin
               write_reg(bcfa_pkg::CSR_SLOTS, 8'd10);
               write_reg(bcfa_pkg::CSR_BLOCKS, 8'd100);
            end
         endcase
      end
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      if (failures == 0) $display("block_chain_file_allocator test passed");
      else $display("block_chain_file_allocator test failed");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("block_chain_file_allocator test failed");
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/bcfa_pkg.sv
hdl/bcfa_ram.sv
hdl/bcfa_ctrl.sv
hdl/bcfa_dp.sv
hdl/block_chain_file_allocator.sv
verif/testbench.sv
